// ===== sv/cd3_pkg.sv =====
// ----------------------------------------------------------------------------
// cd3_pkg
// Widths, constants and stage payload types for the 3-D cosine distance pipe.
// ----------------------------------------------------------------------------
package cd3_pkg;

    localparam int CW     = 16;
    localparam int FB     = 16;

    localparam int IN_W   = 6 * CW;
    localparam int PROD_W = 2 * CW;
    localparam int DOT_W  = 2 * CW + 2;
    localparam int LEN_W  = 2 * CW;
    localparam int L_W    = 4 * CW;
    localparam int QW     = 2 * FB + 1;
    localparam int RW     = FB + 1;
    localparam int OUT_W  = FB + 2;
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

    localparam logic [RW-1:0]    ONE_ROOT = RW'(1) << FB;
    localparam logic [OUT_W-1:0] ONE_OUT  = OUT_W'(1) << FB;
    localparam logic [OUT_W-1:0] TWO_OUT  = OUT_W'(1) << (FB + 1);

    typedef struct packed {
        logic [L_W:0]   rem;
        logic [L_W-1:0] den;
        logic [QW-1:0]  quo;
        logic           neg;
        logic           degen;
    } div_t;

    typedef struct packed {
        logic [2*RW-1:0] rad;
        logic [RW+1:0]   rem;
        logic [RW-1:0]   root;
        logic            neg;
        logic            degen;
    } sqrt_t;

endpackage

// ===== sv/cd3_front.sv =====
// ----------------------------------------------------------------------------
// cd3_front
// Products, sums, and the two wide squares feeding the divider (3 stages).
// ----------------------------------------------------------------------------
module cd3_front
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [cd3_pkg::IN_W-1:0] in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output cd3_pkg::div_t         out_data
);
    import cd3_pkg::*;

    logic                       v1_reg, v2_reg, v3_reg;
    logic                       rdy1, rdy2, rdy3;
    logic signed [PROD_W-1:0]   p_reg [0:5];
    logic signed [PROD_W-1:0]   p_next [0:5];
    logic signed [DOT_W-1:0]    dot_reg, dot_next;
    logic [LEN_W-1:0]           la_reg, la_next, lb_reg, lb_next;
    div_t                       d_reg, d_next;
    logic signed [CW-1:0]       ax, ay, az, bx, by, bz;
    logic [DOT_W-1:0]           mag_full;
    logic [PROD_W-1:0]          mag;
    logic [L_W-1:0]             d2, ll;

    assign ax = in_data[0*CW +: CW];
    assign ay = in_data[1*CW +: CW];
    assign az = in_data[2*CW +: CW];
    assign bx = in_data[3*CW +: CW];
    assign by = in_data[4*CW +: CW];
    assign bz = in_data[5*CW +: CW];

    assign rdy3     = !v3_reg || out_ready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    always_comb
    begin
        p_next[0] = ax * bx;
        p_next[1] = ay * by;
        p_next[2] = az * bz;
        p_next[3] = ax * ax;
        p_next[4] = ay * ay;
        p_next[5] = az * az;
    end

    always_comb
    begin
        dot_next = DOT_W'(p_reg[0]) + DOT_W'(p_reg[1]) + DOT_W'(p_reg[2]);
        la_next  = LEN_W'($unsigned(p_reg[3])) + LEN_W'($unsigned(p_reg[4]))
                 + LEN_W'($unsigned(p_reg[5]));
        lb_next  = '0;
    end

    // b squares share stage 1 through a second set of products
    logic signed [PROD_W-1:0] q_reg [0:2];
    logic signed [PROD_W-1:0] q_next [0:2];

    always_comb
    begin
        q_next[0] = bx * bx;
        q_next[1] = by * by;
        q_next[2] = bz * bz;
    end

    logic [LEN_W-1:0] lb_sum;
    assign lb_sum = LEN_W'($unsigned(q_reg[0])) + LEN_W'($unsigned(q_reg[1]))
                  + LEN_W'($unsigned(q_reg[2]));

    always_comb
    begin
        mag_full     = dot_reg[DOT_W-1] ? -dot_reg : dot_reg;
        mag          = mag_full[PROD_W-1:0];
        d2           = L_W'(mag) * L_W'(mag);
        ll           = L_W'(la_reg) * L_W'(lb_reg);
        d_next.rem   = {1'b0, d2};
        d_next.den   = ll;
        d_next.quo   = '0;
        d_next.neg   = dot_reg[DOT_W-1];
        d_next.degen = (dot_reg == '0) || (la_reg == '0) || (lb_reg == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                v1_reg <= in_valid;
            if (rdy2)
                v2_reg <= v1_reg;
            if (rdy3)
                v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            for (int i = 0; i < 6; i++)
                p_reg[i] <= p_next[i];
            for (int i = 0; i < 3; i++)
                q_reg[i] <= q_next[i];
        end
        if (rdy2)
        begin
            dot_reg <= dot_next;
            la_reg  <= la_next;
            lb_reg  <= lb_sum | lb_next;
        end
        if (rdy3)
            d_reg <= d_next;
    end

    assign out_valid = v3_reg;
    assign out_data  = d_reg;

endmodule

// ===== sv/cd3_div_stage.sv =====
// ----------------------------------------------------------------------------
// cd3_div_stage
// One restoring division step: one quotient bit per stage.
// ----------------------------------------------------------------------------
module cd3_div_stage
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  cd3_pkg::div_t in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output cd3_pkg::div_t out_data
);
    import cd3_pkg::*;

    logic         vld_reg;
    div_t         d_reg, d_next;
    logic         ge;
    logic [L_W:0] diff;

    assign in_ready = !vld_reg || out_ready;

    always_comb
    begin
        ge         = in_data.rem >= {1'b0, in_data.den};
        diff       = ge ? (in_data.rem - {1'b0, in_data.den}) : in_data.rem;
        d_next     = in_data;
        d_next.rem = {diff[L_W-1:0], 1'b0};
        d_next.quo = {in_data.quo[QW-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (in_ready)
            vld_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready)
            d_reg <= d_next;
    end

    assign out_valid = vld_reg;
    assign out_data  = d_reg;

endmodule

// ===== sv/cd3_sqrt_stage.sv =====
// ----------------------------------------------------------------------------
// cd3_sqrt_stage
// One digit-by-digit integer square root step: one root bit per stage.
// ----------------------------------------------------------------------------
module cd3_sqrt_stage
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  cd3_pkg::sqrt_t in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output cd3_pkg::sqrt_t out_data
);
    import cd3_pkg::*;

    logic          vld_reg;
    sqrt_t         s_reg, s_next;
    logic [RW+3:0] cur, trial, diff;
    logic          ge;

    assign in_ready = !vld_reg || out_ready;

    always_comb
    begin
        cur         = {in_data.rem, in_data.rad[2*RW-1 -: 2]};
        trial       = (RW+4)'({in_data.root, 2'b01});
        ge          = cur >= trial;
        diff        = ge ? (cur - trial) : cur;
        s_next      = in_data;
        s_next.rem  = diff[RW+1:0];
        s_next.root = {in_data.root[RW-2:0], ge};
        s_next.rad  = {in_data.rad[2*RW-3:0], 2'b00};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (in_ready)
            vld_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready)
            s_reg <= s_next;
    end

    assign out_valid = vld_reg;
    assign out_data  = s_reg;

endmodule

// ===== sv/cosine_distance_3d.sv =====
// ----------------------------------------------------------------------------
// cosine_distance_3d
// Cosine distance of two signed 3-component vectors, unsigned Q2.16 result.
// ----------------------------------------------------------------------------
// Takes one vector pair per cycle when not held by backpressure and returns
// one result per request, in order. Three front stages form the products, the
// dot product and squared lengths, then dot^2 and |a|^2*|b|^2; a chain of
// restoring divider stages (one quotient bit each) forms floor(dot^2 * 2^32 /
// (|a|^2*|b|^2)); a chain of square-root stages (one root bit each) yields the
// truncated similarity; a last register forms 1 -/+ similarity. Every stage
// has its own valid bit and holds under backpressure, so bubbles collapse and
// nothing is lost or repeated. A zero dot product or length gives exactly 1.0
// with the degenerate flag set.
module cosine_distance_3d
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // a_x, a_y, a_z, b_x, b_y, b_z (16 bits each, signed)
    input  logic [cd3_pkg::IN_W-1:0]         s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // dist_res (18 bits), zero pad
    output logic [cd3_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    // degenerate
    output logic                             m_axis_tuser
);
    import cd3_pkg::*;

    div_t  div_d [0:QW];
    logic  div_v [0:QW];
    logic  div_r [0:QW];
    sqrt_t sq_d  [0:RW];
    logic  sq_v  [0:RW];
    logic  sq_r  [0:RW];

    logic             out_vld_reg;
    logic [OUT_W-1:0] dist_reg, dist_next;
    logic             degen_reg;
    logic [RW-1:0]    q;
    logic [OUT_W-1:0] sum;

    cd3_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_data   (s_axis_tdata),
        .out_valid (div_v[0]),
        .out_ready (div_r[0]),
        .out_data  (div_d[0])
    );

    for (genvar i = 0; i < QW; i++)
    begin : g_div
        cd3_div_stage u_div
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (div_v[i]),
            .in_ready  (div_r[i]),
            .in_data   (div_d[i]),
            .out_valid (div_v[i+1]),
            .out_ready (div_r[i+1]),
            .out_data  (div_d[i+1])
        );
    end

    always_comb
    begin
        sq_d[0].rad   = (2*RW)'(div_d[QW].quo);
        sq_d[0].rem   = '0;
        sq_d[0].root  = '0;
        sq_d[0].neg   = div_d[QW].neg;
        sq_d[0].degen = div_d[QW].degen;
    end
    assign sq_v[0]   = div_v[QW];
    assign div_r[QW] = sq_r[0];

    for (genvar i = 0; i < RW; i++)
    begin : g_sqrt
        cd3_sqrt_stage u_sqrt
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (sq_v[i]),
            .in_ready  (sq_r[i]),
            .in_data   (sq_d[i]),
            .out_valid (sq_v[i+1]),
            .out_ready (sq_r[i+1]),
            .out_data  (sq_d[i+1])
        );
    end

    assign sq_r[RW] = !out_vld_reg || m_axis_tready;

    always_comb
    begin
        q = (sq_d[RW].root > ONE_ROOT) ? ONE_ROOT : sq_d[RW].root;
        if (sq_d[RW].neg)
            sum = ONE_OUT + OUT_W'(q);
        else
            sum = ONE_OUT - OUT_W'(q);
        if (sq_d[RW].degen)
            dist_next = ONE_OUT;
        else if (sum > TWO_OUT)
            dist_next = TWO_OUT;
        else
            dist_next = sum;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (sq_r[RW])
            out_vld_reg <= sq_v[RW];
    end

    always_ff @(posedge clk)
    begin
        if (sq_r[RW])
        begin
            dist_reg  <= dist_next;
            degen_reg <= sq_d[RW].degen;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = OUT_TDATA_W'(dist_reg);
    assign m_axis_tuser  = degen_reg;

    a_degen_one: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> dist_reg == ONE_OUT)
        else $error("degenerate result not 1.0");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> dist_reg <= TWO_OUT)
        else $error("distance out of range");

    a_full_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled while output side moves");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata >> OUT_W) == '0)
        else $error("pad bits not zero");

endmodule

// ===== tb/sv/cosine_distance_3d_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cosine_distance_3d_tb
// Self-checking bench for the 3-D cosine distance pipe: directed corner pairs
// then random pairs, random idling on both sides, a long output hold-off and
// a drain pause. Results are checked in order against a local predictor.
// ----------------------------------------------------------------------------
module cosine_distance_3d_tb;

    import cd3_pkg::*;

    typedef struct packed {
        logic [OUT_W-1:0] dist_val;
        logic             degen;
    } dist_result_t;

    class dist_scoreboard;
        dist_result_t pending[$];
        int           errors;

        // exact truncated similarity, then 1 -/+ q
        function dist_result_t predict(logic [IN_W-1:0] word);
            logic signed [CW-1:0] a[3];
            logic signed [CW-1:0] b[3];
            logic signed [63:0]   dot;
            logic [63:0]          la;
            logic [63:0]          lb;
            logic [63:0]          mag;
            logic [191:0]         rhs;
            logic [191:0]         lens;
            logic [191:0]         sq;
            logic [63:0]          q;
            logic [63:0]          t;
            logic [63:0]          one;
            dist_result_t         r;
            dot = 0;
            la  = 0;
            lb  = 0;
            for (int k = 0; k < 3; k++)
            begin
                a[k] = word[k*CW +: CW];
                b[k] = word[(k+3)*CW +: CW];
                dot += 64'(a[k]) * 64'(b[k]);
                la  += 64'(64'(a[k]) * 64'(a[k]));
                lb  += 64'(64'(b[k]) * 64'(b[k]));
            end
            one = 64'd1 << FB;
            if (dot == 0 || la == 0 || lb == 0)
            begin
                r.dist_val = OUT_W'(one);
                r.degen    = 1'b1;
                return r;
            end
            mag  = dot < 0 ? -dot : dot;
            rhs  = (192'(mag) * 192'(mag)) << (2 * FB);
            lens = 192'(la) * 192'(lb);
            q = 0;
            for (int bi = FB; bi >= 0; bi--)
            begin
                t  = q | (64'd1 << bi);
                sq = 192'(t * t) * lens;
                if (sq <= rhs)
                    q = t;
            end
            if (q > one)
                q = one;
            t = dot > 0 ? one - q : one + q;
            if (t > 2 * one)
                t = 2 * one;
            r.dist_val = OUT_W'(t);
            r.degen    = 1'b0;
            return r;
        endfunction

        function void note_request(logic [IN_W-1:0] word);
            pending.push_back(predict(word));
        endfunction

        function void check_result(logic [OUT_TDATA_W-1:0] data, logic user);
            dist_result_t e;
            if (pending.size() == 0)
            begin
                $error("unexpected result dist_res=%0d degenerate=%0d", data[OUT_W-1:0], user);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (data[OUT_W-1:0] !== e.dist_val)
            begin
                $error("dist_res: expected %0d, got %0d", e.dist_val, data[OUT_W-1:0]);
                errors++;
            end
            if (data[OUT_TDATA_W-1:OUT_W] !== '0)
            begin
                $error("pad: expected 0, got %0h", data[OUT_TDATA_W-1:OUT_W]);
                errors++;
            end
            if (user !== e.degen)
            begin
                $error("degenerate: expected %0d, got %0d", e.degen, user);
                errors++;
            end
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_W-1:0]        s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tuser;

    dist_scoreboard sb;
    bit             calm_in;
    bit             calm_out;
    bit             hold_out;

    cosine_distance_3d u_top
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic logic [IN_W-1:0] pack_pair(int ax, int ay, int az, int bx, int by,
                                                  int bz);
        return {CW'(bz), CW'(by), CW'(bx), CW'(az), CW'(ay), CW'(ax)};
    endfunction

    function automatic logic [CW-1:0] rand_comp(int mode);
        case (mode)
            0:       return CW'($urandom);
            1:       return CW'($urandom_range(0, 15)) - CW'(8);
            2:       return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
            default: return CW'($urandom_range(0, 511)) - CW'(256);
        endcase
    endfunction

    // one request, idling before it at random
    task automatic send_request(logic [IN_W-1:0] word);
        while (!calm_in && $urandom_range(0, 99) < 15)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_request(word);
    endtask

    task automatic idle_input();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
    endtask

    // result side
    initial
    begin
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata, m_axis_tuser);
            m_axis_tready <= !hold_out && (calm_out || $urandom_range(0, 99) >= 15);
        end
    end

    initial
    begin
        logic [IN_W-1:0] w;
        int              mode;
        int              waited;
        sb            = new();
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        calm_in       = 1'b0;
        calm_out      = 1'b0;
        hold_out      = 1'b0;
        rst_n         = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(pack_pair(0, 0, 0, 0, 0, 0));
        send_request(pack_pair(1, 2, 3, 0, 0, 0));
        send_request(pack_pair(0, 0, 0, 4, 5, 6));
        send_request(pack_pair(1, 0, 0, 0, 1, 0));
        send_request(pack_pair(3, 4, 5, 3, 4, 5));
        send_request(pack_pair(3, 4, 5, -3, -4, -5));
        send_request(pack_pair(32767, 32767, 32767, 32767, 32767, 32767));
        send_request(pack_pair(-32768, -32768, -32768, -32768, -32768, -32768));
        send_request(pack_pair(-32768, -32768, -32768, 32767, 32767, 32767));
        send_request(pack_pair(-32768, 0, 0, 32767, 0, 0));
        send_request(pack_pair(-1, -1, -1, -1, -1, -1));
        send_request(pack_pair(-1, 0, 0, 1, 1, 0));
        send_request(pack_pair(1, 2, 3, 4, 5, 6));
        send_request(pack_pair(1, 2, 3, -4, 5, -6));
        send_request(pack_pair(1, 1, 0, 1, 0, 0));
        send_request(pack_pair(32767, -32768, 1, -1, 32767, -32768));
        send_request(pack_pair(2, 3, 1, -3, 2, 1));
        send_request(pack_pair(-32768, 32767, -32768, 32767, -32768, 32767));

        for (int n = 0; n < 800; n++)
        begin
            if (n == 100)
            begin
                idle_input();
                while (sb.pending.size() != 0)
                    @(posedge clk);
            end
            calm_in  = (n >= 300 && n < 400);
            calm_out = (n >= 300 && n < 400);
            if (n == 500)
            begin
                hold_out = 1'b1;
                fork
                    begin
                        repeat (300) @(posedge clk);
                        hold_out = 1'b0;
                    end
                join_none
            end
            mode = $urandom_range(0, 3);
            for (int k = 0; k < 6; k++)
                w[k*CW +: CW] = rand_comp($urandom_range(0, 4) == 0 ? $urandom_range(0, 3)
                                                                    : mode);
            send_request(w);
        end
        idle_input();

        waited = 0;
        while (sb.pending.size() != 0 && waited < 100000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (100) @(posedge clk);
        if (sb.pending.size() == 0 && sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/cd3_pkg.sv
sv/cd3_front.sv
sv/cd3_div_stage.sv
sv/cd3_sqrt_stage.sv
sv/cosine_distance_3d.sv
tb/sv/cosine_distance_3d_tb.sv
